// ----- src/lkv_pkg.sv -----
package lkv_pkg;

   localparam int DEPTH     = 64;
   localparam int TAG_BITS  = 32;
   localparam int DATA_BITS = 32;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int LIM_W = (CNT_W > 7) ? CNT_W : 7;
   // exact sum of DEPTH 32-bit hit counters
   localparam int SUM_W = 32 + IDX_W + 1;

   localparam logic [30:0] BUDGET_RESET = 31'd104857600;
   localparam logic [30:0] LIFE_RESET   = 31'd3600;

   typedef enum logic [2:0] {
      CMD_PUT    = 3'd0,
      CMD_GET    = 3'd1,
      CMD_REMOVE = 3'd2,
      CMD_CLEAR  = 3'd3,
      CMD_TICK   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MISS     = 2'd1,
      ST_EXPIRED  = 2'd2,
      ST_DISABLED = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_ENABLE = 2'd0,
      REG_LIMIT  = 2'd1,
      REG_BUDGET = 2'd2,
      REG_LIFE   = 2'd3
   } reg_type;

   typedef enum logic [1:0] {
      S_IDLE   = 2'd0,
      S_SCAN   = 2'd1,
      S_DRAIN  = 2'd2,
      S_UPDATE = 2'd3
   } state_type;

   typedef struct packed {
      logic [31:0]          order;
      logic [15:0]          cost;
      logic [31:0]          hits;
      logic [31:0]          birth;
      logic [DATA_BITS-1:0] data;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   // what one pass over the table found
   typedef struct packed {
      logic             m_found;
      logic [IDX_W-1:0] m_idx;
      entry_type        m_entry;
      logic             v_found;
      logic [IDX_W-1:0] v_idx;
      logic [31:0]      v_hits;
      logic [15:0]      v_cost;
      logic             f_found;
      logic [IDX_W-1:0] f_idx;
      logic [SUM_W-1:0] sum;
   } scan_type;

endpackage

// ----- src/lkv_ram.sv -----
module lkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/lkv_scan.sv -----
// Walks the read beats of one table pass: oldest tag match, LFU victim,
// first free slot and the exact hit sum.
module lkv_scan (
   input  logic                          clock,
   input  logic                          start,
   input  logic                          beat,
   input  logic [lkv_pkg::IDX_W-1:0]     beat_idx,
   input  logic                          beat_valid,
   input  lkv_pkg::entry_type            beat_entry,
   input  logic [lkv_pkg::TAG_BITS-1:0]  key,
   input  logic [31:0]                   next_order,
   output lkv_pkg::scan_type             res
);

   lkv_pkg::scan_type res_ff, res_in;
   logic [31:0] m_age_ff, m_age_in, v_age_ff, v_age_in;
   logic [31:0] age;

   always_comb begin
      res_in   = res_ff;
      m_age_in = m_age_ff;
      v_age_in = v_age_ff;
      age      = next_order - beat_entry.order;
      if (start) begin
         res_in.m_found = 1'b0;
         res_in.v_found = 1'b0;
         res_in.f_found = 1'b0;
         res_in.sum     = '0;
      end else if (beat) begin
         if (beat_valid) begin
            if (beat_entry.tag == key && (!res_ff.m_found || age > m_age_ff)) begin
               res_in.m_found = 1'b1;
               res_in.m_idx   = beat_idx;
               res_in.m_entry = beat_entry;
               m_age_in       = age;
            end
            if (!res_ff.v_found || beat_entry.hits < res_ff.v_hits ||
                (beat_entry.hits == res_ff.v_hits && age > v_age_ff)) begin
               res_in.v_found = 1'b1;
               res_in.v_idx   = beat_idx;
               res_in.v_hits  = beat_entry.hits;
               res_in.v_cost  = beat_entry.cost;
               v_age_in       = age;
            end
            res_in.sum = res_ff.sum + lkv_pkg::SUM_W'(beat_entry.hits);
         end else if (!res_ff.f_found) begin
            res_in.f_found = 1'b1;
            res_in.f_idx   = beat_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      res_ff   <= res_in;
      m_age_ff <= m_age_in;
      v_age_ff <= v_age_in;
   end

   assign res = res_ff;

endmodule

// ----- src/lfu_ttl_kv_cache_top.sv -----
// LFU key/value cache with byte budget and time to live. The entry RAM is
// read once per cycle over all slots to find the oldest match, the eviction
// victim, the first free slot and the hit sum. A drain state then covers the
// RAM read latency, and a single update state writes back. The update state
// waits for as long as the previous result is still held in the output
// register. One transaction is in flight at a time, so a new one is taken
// only after the last one has written back. The next one is accepted while
// the previous result waits in the output register. Slot valid bits are
// flip-flops, so reset and clear take effect at once.
module lfu_ttl_kv_cache_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [30:0]  csr_wdata,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,   // tag[31:0], data_in[63:32], cost_bytes[79:64]
   input  logic [2:0]   req_tuser,   // cmd[2:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // data_out, entry_count, bytes_used, hit_total, pad
   output logic [1:0]   rsp_tuser    // status[1:0]
);

   localparam int EW = $bits(lkv_pkg::entry_type);
   localparam logic [lkv_pkg::SUM_W-1:0] SAT = lkv_pkg::SUM_W'(32'hFFFF_FFFF);

   lkv_pkg::state_type state_ff, state_in;
   logic [lkv_pkg::IDX_W-1:0] cnt_ff, cnt_in;
   logic                      beat_ff;
   logic [lkv_pkg::IDX_W-1:0] beat_idx_ff;
   logic                      beat_valid;

   logic        enable_ff;
   logic [6:0]  limit_ff;
   logic [30:0] budget_ff, life_ff;

   logic [2:0]                   cmd_ff;
   logic [lkv_pkg::TAG_BITS-1:0] tag_ff;
   logic [lkv_pkg::DATA_BITS-1:0] data_ff;
   logic [15:0]                  cost_ff;

   logic [lkv_pkg::DEPTH-1:0] valid_ff, valid_in;
   logic [lkv_pkg::CNT_W-1:0] held_ff, held_in;
   logic [31:0] bytes_ff, bytes_in, now_ff, now_in, order_ff, order_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [103:0] rsp_data_ff, rsp_data_in;
   logic [1:0]   rsp_user_ff, rsp_user_in;

   logic                      we;
   logic [lkv_pkg::IDX_W-1:0] waddr;
   lkv_pkg::entry_type        wentry, rentry;
   lkv_pkg::scan_type         sres;

   logic accept, start;
   logic [lkv_pkg::LIM_W-1:0] lim;
   logic [lkv_pkg::SUM_W-1:0] sum_new;
   logic [31:0] dout, hit_total;
   lkv_pkg::status_type status;
   logic evict;
   logic [lkv_pkg::IDX_W-1:0] slot;
   logic [63:0] tag_ext, data_ext, mdata_ext;

   assign req_tready = (state_ff == lkv_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign start      = accept;
   assign tag_ext    = {32'd0, req_tdata[31:0]};
   assign data_ext   = {32'd0, req_tdata[63:32]};
   assign beat_valid = valid_ff[beat_idx_ff];

   lkv_ram #(.WIDTH(EW), .DEPTH(lkv_pkg::DEPTH)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wentry),
      .raddr (cnt_ff),
      .rdata (rentry)
   );

   lkv_scan u_scan (
      .clock      (clock),
      .start      (start),
      .beat       (beat_ff),
      .beat_idx   (beat_idx_ff),
      .beat_valid (beat_valid),
      .beat_entry (rentry),
      .key        (tag_ff),
      .next_order (order_ff),
      .res        (sres)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         limit_ff  <= 7'd64;
         budget_ff <= lkv_pkg::BUDGET_RESET;
         life_ff   <= lkv_pkg::LIFE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            lkv_pkg::REG_ENABLE: enable_ff <= csr_wdata[0];
            lkv_pkg::REG_LIMIT:  limit_ff  <= csr_wdata[6:0];
            lkv_pkg::REG_BUDGET: budget_ff <= csr_wdata;
            lkv_pkg::REG_LIFE:   life_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff  <= req_tuser;
         tag_ff  <= tag_ext[lkv_pkg::TAG_BITS-1:0];
         data_ff <= data_ext[lkv_pkg::DATA_BITS-1:0];
         cost_ff <= req_tdata[79:64];
      end
      beat_idx_ff <= cnt_ff;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_comb begin
      // entry limit: 0 acts as 1, above DEPTH acts as DEPTH
      if (limit_ff == 7'd0) begin
         lim = lkv_pkg::LIM_W'(1);
      end else if (lkv_pkg::LIM_W'(limit_ff) > lkv_pkg::LIM_W'(lkv_pkg::DEPTH)) begin
         lim = lkv_pkg::LIM_W'(lkv_pkg::DEPTH);
      end else begin
         lim = lkv_pkg::LIM_W'(limit_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      valid_in     = valid_ff;
      held_in      = held_ff;
      bytes_in     = bytes_ff;
      now_in       = now_ff;
      order_in     = order_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      we           = 1'b0;
      waddr        = sres.m_idx;
      wentry       = sres.m_entry;
      sum_new      = sres.sum;
      dout         = 32'd0;
      status       = lkv_pkg::ST_OK;
      evict        = 1'b0;
      slot         = sres.f_idx;
      mdata_ext    = 64'(sres.m_entry.data);
      hit_total    = 32'd0;

      case (state_ff)
         lkv_pkg::S_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = lkv_pkg::S_SCAN;
            end
         end
         lkv_pkg::S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == lkv_pkg::IDX_W'(lkv_pkg::DEPTH - 1)) begin
               cnt_in   = cnt_ff;
               state_in = lkv_pkg::S_DRAIN;
            end
         end
         lkv_pkg::S_DRAIN: begin
            state_in = lkv_pkg::S_UPDATE;
         end
         lkv_pkg::S_UPDATE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = lkv_pkg::S_IDLE;
               case (cmd_ff)
                  lkv_pkg::CMD_PUT: begin
                     if (enable_ff) begin
                        evict = sres.v_found &&
                                (lkv_pkg::LIM_W'(held_ff) >= lim ||
                                 ({1'b0, bytes_ff} + 33'(cost_ff)) > 33'(budget_ff));
                        if (evict) begin
                           valid_in[sres.v_idx] = 1'b0;
                           bytes_in = bytes_in - 32'(sres.v_cost);
                           held_in  = held_in - 1'b1;
                           sum_new  = sum_new - lkv_pkg::SUM_W'(sres.v_hits);
                           if (!sres.f_found || sres.v_idx < sres.f_idx) begin
                              slot = sres.v_idx;
                           end
                        end
                        if (evict || sres.f_found) begin
                           we           = 1'b1;
                           waddr        = slot;
                           wentry.tag   = tag_ff;
                           wentry.data  = data_ff;
                           wentry.birth = now_ff;
                           wentry.hits  = 32'd0;
                           wentry.cost  = cost_ff;
                           wentry.order = order_ff;
                           valid_in[slot] = 1'b1;
                           order_in = order_ff + 32'd1;
                           held_in  = held_in + 1'b1;
                           bytes_in = bytes_in + 32'(cost_ff);
                        end
                     end
                  end
                  lkv_pkg::CMD_GET: begin
                     if (!enable_ff) begin
                        status = lkv_pkg::ST_DISABLED;
                     end else if (!sres.m_found) begin
                        status = lkv_pkg::ST_MISS;
                     end else if ((now_ff - sres.m_entry.birth) > 32'(life_ff)) begin
                        status = lkv_pkg::ST_EXPIRED;
                        valid_in[sres.m_idx] = 1'b0;
                        bytes_in = bytes_ff - 32'(sres.m_entry.cost);
                        held_in  = held_ff - 1'b1;
                        sum_new  = sres.sum - lkv_pkg::SUM_W'(sres.m_entry.hits);
                     end else begin
                        dout = mdata_ext[31:0];
                        if (sres.m_entry.hits != 32'hFFFF_FFFF) begin
                           we          = 1'b1;
                           wentry.hits = sres.m_entry.hits + 32'd1;
                           sum_new     = sres.sum + lkv_pkg::SUM_W'(1);
                        end
                     end
                  end
                  lkv_pkg::CMD_REMOVE: begin
                     if (!sres.m_found) begin
                        status = lkv_pkg::ST_MISS;
                     end else begin
                        valid_in[sres.m_idx] = 1'b0;
                        bytes_in = bytes_ff - 32'(sres.m_entry.cost);
                        held_in  = held_ff - 1'b1;
                        sum_new  = sres.sum - lkv_pkg::SUM_W'(sres.m_entry.hits);
                     end
                  end
                  lkv_pkg::CMD_CLEAR: begin
                     valid_in = '0;
                     held_in  = '0;
                     bytes_in = 32'd0;
                     sum_new  = '0;
                  end
                  lkv_pkg::CMD_TICK: begin
                     now_in = now_ff + 32'd1;
                  end
                  default: ;
               endcase
               hit_total    = (sum_new > SAT) ? 32'hFFFF_FFFF : sum_new[31:0];
               rsp_valid_in = 1'b1;
               rsp_user_in  = status;
               rsp_data_in  = {1'b0, hit_total, bytes_in, 7'(held_in), dout};
            end
         end
         default: begin
            state_in = lkv_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lkv_pkg::S_IDLE;
         cnt_ff       <= '0;
         beat_ff      <= 1'b0;
         valid_ff     <= '0;
         held_ff      <= '0;
         bytes_ff     <= 32'd0;
         now_ff       <= 32'd0;
         order_ff     <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         beat_ff      <= (state_ff == lkv_pkg::S_SCAN);
         valid_ff     <= valid_in;
         held_ff      <= held_in;
         bytes_ff     <= bytes_in;
         now_ff       <= now_in;
         order_ff     <= order_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_count_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == 32'(held_ff))
      else $error("held count differs from valid bits");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      32'(held_ff) <= 32'(lkv_pkg::DEPTH))
      else $error("held count above depth");

   a_accept_scans: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == lkv_pkg::S_SCAN))
      else $error("accepted transaction did not start a scan");

endmodule
